FILE: rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the barometric compensation block
// Calibration record, front-to-back item, pipeline sideband and register map.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);
  localparam int DIV_STAGES = 64;

  localparam logic [31:0] FINE_OFFSET = 32'd128000;
  localparam logic [20:0] RAW_FULL    = 21'd1048576;
  localparam logic [11:0] DIV_SCALE   = 12'd3125;
  localparam logic [63:0] P1_BASE     = 64'd1 << 47;
  localparam int          P4_SHIFT    = 35;
  localparam int          P1_SHIFT    = 33;

  typedef enum logic [1:0] {
    REG_TEMP_CALIB = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_HIGH = 2'd2,
    REG_PRESS_LAST = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } calib_t;

  typedef struct packed {
    logic [19:0] raw_p;
    logic [31:0] fine;
    logic [31:0] centi;
  } front_item_t;

  typedef struct packed {
    logic [31:0] centi;
    logic        invalid;
    logic        neg;
  } side_t;

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    sx16_64 = {{48{v[15]}}, v};
  endfunction

endpackage

FILE: rtl/core/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation: barometric sensor compensation, top level
// Calibration registers, temperature front, queue and pressure back.
// ----------------------------------------------------------------------------
// path: 4 temperature stages, the queue, 8 pressure stages, the 64-stage
//   divider, 4 post stages and the output register
// throughput: one item per cycle while no stall holds the flow; the radix-2
//   divider is fully pipelined
// reset: synchronous active-low rst_n clears calibration to zero and empties
//   every stage and the queue; no clearing pass is needed
module baro_temp_pressure_compensation import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_temperature_centi,
  output logic [31:0] out_pressure_q24_8,
  output logic        out_pressure_invalid
);

  logic [47:0] temp_calib_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_last_r;
  calib_t      cal;

  logic        q_push, q_pop, q_full, q_empty;
  front_item_t q_in, q_head;

  // calibration writes, only while idle: a rule on the user, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_last_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TEMP_CALIB: temp_calib_r <= cfg_wr_data[47:0];
        REG_PRESS_LOW:  press_low_r  <= cfg_wr_data;
        REG_PRESS_HIGH: press_high_r <= cfg_wr_data;
        REG_PRESS_LAST: press_last_r <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  // unpack the sixteen-bit calibration lanes
  assign cal.t1 = temp_calib_r[15:0];
  assign cal.t2 = temp_calib_r[31:16];
  assign cal.t3 = temp_calib_r[47:32];
  assign cal.p1 = press_low_r[15:0];
  assign cal.p2 = press_low_r[31:16];
  assign cal.p3 = press_low_r[47:32];
  assign cal.p4 = press_low_r[63:48];
  assign cal.p5 = press_high_r[15:0];
  assign cal.p6 = press_high_r[31:16];
  assign cal.p7 = press_high_r[47:32];
  assign cal.p8 = press_high_r[63:48];
  assign cal.p9 = press_last_r;

  // front: fine temperature and centidegrees
  bpc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .cal                (cal),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (q_in)
  );

  // queue decouples the two halves so each stalls on its own
  bpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: pressure path, divider and output register
  bpc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cal                   (cal),
    .q_empty               (q_empty),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_q24_8    (out_pressure_q24_8),
    .out_pressure_invalid  (out_pressure_invalid)
  );

  // a zero divisor always forces the pressure to zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pressure_invalid) |-> (out_pressure_q24_8 == 32'd0))
    else $error("invalid pressure not forced to zero");

endmodule

FILE: rtl/core/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: temperature stages
// Takes raw samples, forms fine temperature and centidegrees in 32-bit math.
// ----------------------------------------------------------------------------
module bpc_front import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  input  calib_t      cal,
  input  logic        q_full,
  output logic        q_push,
  output front_item_t q_item
);

  logic [3:0]  vld_r;
  logic        fe;
  logic [31:0] diff_a, t2x, t3x, d32;
  logic [31:0] a_nxt, dd_nxt, va_nxt, dd_sh, vb0_nxt, vb, fine_nxt, f5, centi_nxt;
  logic [31:0] a_r, dd_r, va_r, vb0_r, fine_r;
  logic [19:0] rp1_r, rp2_r, rp3_r;
  front_item_t item_r;

  assign fe       = !(vld_r[3] && q_full);
  assign in_stall = !fe;
  assign q_push   = vld_r[3] && !q_full;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (fe) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  // stage 1: two products
  assign t2x     = {{16{cal.t2[15]}}, cal.t2};
  assign t3x     = {{16{cal.t3[15]}}, cal.t3};
  assign diff_a  = {15'd0, in_raw_temperature[19:3]} - {15'd0, cal.t1, 1'b0};
  assign a_nxt   = diff_a * t2x;
  assign d32     = {16'd0, in_raw_temperature[19:4]} - {16'd0, cal.t1};
  assign dd_nxt  = d32 * d32;

  // stage 2
  assign va_nxt  = $signed(a_r) >>> 11;
  assign dd_sh   = $signed(dd_r) >>> 12;
  assign vb0_nxt = dd_sh * t3x;

  // stage 3
  assign vb       = $signed(vb0_r) >>> 14;
  assign fine_nxt = va_r + vb;

  // stage 4: (fine * 5 + 128) >> 8
  assign f5        = (fine_r << 2) + fine_r + 32'd128;
  assign centi_nxt = $signed(f5) >>> 8;

  always_ff @(posedge clk) begin
    if (fe) begin
      a_r          <= a_nxt;
      dd_r         <= dd_nxt;
      rp1_r        <= in_raw_pressure;
      va_r         <= va_nxt;
      vb0_r        <= vb0_nxt;
      rp2_r        <= rp1_r;
      fine_r       <= fine_nxt;
      rp3_r        <= rp2_r;
      item_r.fine  <= fine_r;
      item_r.centi <= centi_nxt;
      item_r.raw_p <= rp3_r;
    end
  end

endmodule

FILE: rtl/core/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue: small queue between front and back
// Flip-flop storage, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module bpc_queue import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  front_item_t push_item,
  input  logic        pop,
  output front_item_t head,
  output logic        full,
  output logic        empty
);

  front_item_t    mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCW'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH)) else $error("queue count beyond depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + QCW'(1)))
    else $error("queue count did not grow on push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0)) else $error("pop from empty queue");

endmodule

FILE: rtl/core/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div: pipelined unsigned 64-bit divider
// One restoring step per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] in_num,
  input  logic [63:0] in_den,
  input  side_t       in_side,
  output logic        out_vld,
  output logic [63:0] out_quo,
  output side_t       out_side
);

  logic [63:0] rem_w  [0:DIV_STAGES];
  logic [63:0] quo_w  [0:DIV_STAGES];
  logic [63:0] den_w  [0:DIV_STAGES];
  side_t       side_w [0:DIV_STAGES];
  logic [DIV_STAGES:0] vld_w;

  logic [63:0] rem_r  [DIV_STAGES];
  logic [63:0] quo_r  [DIV_STAGES];
  logic [63:0] den_r  [DIV_STAGES];
  side_t       side_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;

  assign rem_w[0]  = '0;
  assign quo_w[0]  = in_num;
  assign den_w[0]  = in_den;
  assign side_w[0] = in_side;
  assign vld_w[0]  = in_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_w[DIV_STAGES-1:0];
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
    logic [64:0] trial;
    logic        ge;
    assign trial = {rem_w[g], quo_w[g][63]} - {1'b0, den_w[g]};
    assign ge    = !trial[64];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? trial[63:0] : {rem_w[g][62:0], quo_w[g][63]};
        quo_r[g]  <= {quo_w[g][62:0], ge};
        den_r[g]  <= den_w[g];
        side_r[g] <= side_w[g];
      end
    end

    assign rem_w[g+1]  = rem_r[g];
    assign quo_w[g+1]  = quo_r[g];
    assign den_w[g+1]  = den_r[g];
    assign side_w[g+1] = side_r[g];
    assign vld_w[g+1]  = vld_r[g];
  end

  assign out_vld  = vld_w[DIV_STAGES];
  assign out_quo  = quo_w[DIV_STAGES];
  assign out_side = side_w[DIV_STAGES];

endmodule

FILE: rtl/core/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: pressure stages
// 64-bit pressure compensation with the pipelined divider and output register.
// ----------------------------------------------------------------------------
module bpc_back import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  calib_t      cal,
  input  logic        q_empty,
  input  front_item_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_temperature_centi,
  output logic [31:0] out_pressure_q24_8,
  output logic        out_pressure_invalid
);

  logic        en;
  logic [8:1]  bv_r;
  logic [4:1]  ev_r;
  logic        ov_r;

  // b1
  logic [63:0] fine64, v1_nxt, v1_r;
  logic [19:0] rp1_r, rp2_r, rp3_r, rp4_r, rp5_r;
  side_t       sd1_r, sd2_r, sd3_r, sd4_r, sd5_r, sd6_r, sd7_r, sd8_r, sd_nxt;
  // b2
  logic signed [65:0] sq_full;
  logic signed [48:0] m5, m2;
  logic [63:0] sq_r, v1p5_r, v1p2_r;
  // b3
  logic signed [79:0] m6, m3;
  logic [63:0] v2a_r, t3a_r, v1p5b_r, v1p2b_r;
  // b4
  logic [63:0] t3s, v2_nxt, xb_nxt, v2_r, xb_r;
  // b5
  logic [79:0] y_full;
  logic [63:0] y_r, v2b_r;
  // b6
  logic [63:0] den_nxt, num_nxt, den_r, num_r;
  logic [20:0] pp;
  // b7
  logic [75:0] n3_full;
  logic [63:0] n3_r, den7_r;
  // b8
  logic [63:0] an_r, ad_r;
  // divider
  logic        dv_vld;
  logic [63:0] dv_quo;
  side_t       dv_side;
  // e stages
  logic [63:0] q_nxt, q1_r, q2_r, q3_r, q4_r;
  side_t       se1_r, se2_r, se3_r, se4_r;
  logic [63:0] ps, w2s;
  logic signed [79:0] m9, m8;
  logic [63:0] ps_r, m1_r, w2_r, w2c_r, w2d_r;
  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;
  logic [63:0] prod, w1_nxt, w1_r;
  logic [63:0] sum, sum_sh, res;
  logic [31:0] cen_r, pr_r;
  logic        inv_r;

  assign en    = !ov_r || !out_stall;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
      ev_r <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      bv_r <= {bv_r[7:1], !q_empty};
      ev_r <= {ev_r[3:1], dv_vld};
      ov_r <= ev_r[4];
    end
  end

  // b1: offset fine temperature
  assign fine64 = {{32{q_head.fine[31]}}, q_head.fine};
  assign v1_nxt = fine64 - {32'd0, FINE_OFFSET};
  always_comb begin
    sd_nxt         = '0;
    sd_nxt.centi   = q_head.centi;
  end

  // b2: products of v1
  assign sq_full = $signed(v1_r[32:0]) * $signed(v1_r[32:0]);
  assign m5      = $signed(v1_r[32:0]) * $signed(cal.p5);
  assign m2      = $signed(v1_r[32:0]) * $signed(cal.p2);

  // b3: v1 squared times p6, p3
  assign m6 = $signed(sq_r) * $signed(cal.p6);
  assign m3 = $signed(sq_r) * $signed(cal.p3);

  // b4: sums
  assign t3s    = $signed(t3a_r) >>> 8;
  assign v2_nxt = v2a_r + (v1p5b_r << 17) + (sx16_64(cal.p4) << P4_SHIFT);
  assign xb_nxt = t3s + (v1p2b_r << 12) + P1_BASE;

  // b5
  assign y_full = xb_r * cal.p1;

  // b6: divisor and numerator
  assign den_nxt = $signed(y_r) >>> P1_SHIFT;
  assign pp      = RAW_FULL - {1'b0, rp5_r};
  assign num_nxt = ({43'd0, pp} << 31) - v2b_r;

  // b7
  assign n3_full = num_r * DIV_SCALE;

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r    <= v1_nxt;
      rp1_r   <= q_head.raw_p;
      sd1_r   <= sd_nxt;
      sq_r    <= sq_full[63:0];
      v1p5_r  <= {{15{m5[48]}}, m5};
      v1p2_r  <= {{15{m2[48]}}, m2};
      rp2_r   <= rp1_r;
      sd2_r   <= sd1_r;
      v2a_r   <= m6[63:0];
      t3a_r   <= m3[63:0];
      v1p5b_r <= v1p5_r;
      v1p2b_r <= v1p2_r;
      rp3_r   <= rp2_r;
      sd3_r   <= sd2_r;
      v2_r    <= v2_nxt;
      xb_r    <= xb_nxt;
      rp4_r   <= rp3_r;
      sd4_r   <= sd3_r;
      y_r     <= y_full[63:0];
      v2b_r   <= v2_r;
      rp5_r   <= rp4_r;
      sd5_r   <= sd4_r;
      den_r   <= den_nxt;
      num_r   <= num_nxt;
      sd6_r   <= sd5_r;
      n3_r    <= n3_full[63:0];
      den7_r  <= den_r;
      sd7_r   <= '{centi: sd6_r.centi, invalid: (den_r == '0), neg: sd6_r.neg};
      // b8: magnitudes and result sign
      an_r    <= n3_r[63] ? (64'd0 - n3_r) : n3_r;
      ad_r    <= den7_r[63] ? (64'd0 - den7_r) : den7_r;
      sd8_r   <= '{centi: sd7_r.centi, invalid: sd7_r.invalid,
                   neg: n3_r[63] ^ den7_r[63]};
    end
  end

  bpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (bv_r[8]),
    .in_num   (an_r),
    .in_den   (ad_r),
    .in_side  (sd8_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // e1: signed quotient
  assign q_nxt = dv_side.neg ? (64'd0 - dv_quo) : dv_quo;

  // e2: p9 * ps and p8 * p
  assign ps  = $signed(q1_r) >>> 13;
  assign m9  = $signed(ps) * $signed(cal.p9);
  assign m8  = $signed(q1_r) * $signed(cal.p8);
  assign w2s = $signed(m8[63:0]) >>> 19;

  // e4: reassemble the low 64 bits of m1 * ps
  assign prod   = ll_r + {lh_r + hl_r, 32'd0};
  assign w1_nxt = $signed(prod) >>> 25;

  // output stage
  assign sum    = q4_r + w1_r + w2d_r;
  assign sum_sh = $signed(sum) >>> 8;
  assign res    = sum_sh + (sx16_64(cal.p7) << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r  <= q_nxt;
      se1_r <= dv_side;
      ps_r  <= ps;
      m1_r  <= m9[63:0];
      w2_r  <= w2s;
      q2_r  <= q1_r;
      se2_r <= se1_r;
      ll_r  <= m1_r[31:0] * ps_r[31:0];
      lh_r  <= m1_r[31:0] * ps_r[63:32];
      hl_r  <= m1_r[63:32] * ps_r[31:0];
      w2c_r <= w2_r;
      q3_r  <= q2_r;
      se3_r <= se2_r;
      w1_r  <= w1_nxt;
      w2d_r <= w2c_r;
      q4_r  <= q3_r;
      se4_r <= se3_r;
      cen_r <= se4_r.centi;
      inv_r <= se4_r.invalid;
      pr_r  <= se4_r.invalid ? 32'd0 : res[31:0];
    end
  end

  assign out_valid             = ov_r;
  assign out_temperature_centi = cen_r;
  assign out_pressure_q24_8    = pr_r;
  assign out_pressure_invalid  = inv_r;

endmodule

FILE: tb/sv/baro_temp_pressure_compensation_test.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_test: self-checking bench for the block
// Drives raw sample pairs through several calibration sets, predicts each
// compensated temperature and pressure, and checks every result transfer
// in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module baro_temp_pressure_compensation_test import bpc_pkg::*;;

  typedef struct {
    logic [31:0] centi;
    logic [31:0] press;
    logic        inv;
  } sample_result_t;

  // expected results in transfer order, with a private copy of the calibration
  class compensation_board;
    logic [63:0]    cal_temp, cal_plo, cal_phi, cal_plast;
    sample_result_t pending_q[$];
    int             errors;

    function new();
      cal_temp = '0; cal_plo = '0; cal_phi = '0; cal_plast = '0;
      errors = 0;
    endfunction

    function void load(cfg_reg_t idx, logic [63:0] data);
      case (idx)
        REG_TEMP_CALIB: cal_temp  = {16'h0, data[47:0]};
        REG_PRESS_LOW:  cal_plo   = data;
        REG_PRESS_HIGH: cal_phi   = data;
        REG_PRESS_LAST: cal_plast = {48'h0, data[15:0]};
        default: ;
      endcase
    endfunction

    function automatic logic signed [63:0] lane(logic [63:0] w, int n);
      logic [15:0] v;
      v = w[16*n +: 16];
      return {{48{v[15]}}, v};
    endfunction

    function automatic sample_result_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
      sample_result_t r;
      logic signed [31:0] adct, t1, t2, t3, a, va, d, vb, fine;
      logic signed [63:0] f64, v1, v2, p, num, ps, w1, w2;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] an, ad, q;
      adct = {12'h0, raw_t};
      t1 = {16'h0, cal_temp[15:0]};
      t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
      t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
      a  = ((adct >>> 3) - (t1 <<< 1)) * t2;
      va = a >>> 11;
      d  = (adct >>> 4) - t1;
      vb = (((d * d) >>> 12) * t3) >>> 14;
      fine = va + vb;
      r.centi = (fine * 5 + 128) >>> 8;

      p1 = {48'h0, cal_plo[15:0]};
      p2 = lane(cal_plo, 1); p3 = lane(cal_plo, 2); p4 = lane(cal_plo, 3);
      p5 = lane(cal_phi, 0); p6 = lane(cal_phi, 1);
      p7 = lane(cal_phi, 2); p8 = lane(cal_phi, 3);
      p9 = lane(cal_plast, 0);

      f64 = fine;
      v1 = f64 - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

      r.press = '0;
      r.inv   = (v1 == 0);
      if (!r.inv) begin
        p   = 64'sd1048576 - {44'h0, raw_p};
        num = ((p <<< 31) - v2) * 64'sd3125;
        // truncating division on magnitudes, so min / -1 wraps like the hardware
        an = num[63] ? -num : num;
        ad = v1[63] ? -v1 : v1;
        q  = an / ad;
        p  = (num[63] != v1[63]) ? -q : q;
        ps = p >>> 13;
        w1 = (p9 * ps * ps) >>> 25;
        w2 = (p8 * p) >>> 19;
        p  = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
        r.press = p[31:0];
      end
      return r;
    endfunction

    function void note_input(logic [19:0] raw_t, logic [19:0] raw_p);
      pending_q.push_back(compensate(raw_t, raw_p));
    endfunction

    function void check_result(logic [31:0] centi, logic [31:0] press, logic inv);
      sample_result_t e;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (centi !== e.centi) begin
        $error("temperature_centi expected %0d got %0d", $signed(e.centi), $signed(centi));
        errors++;
      end
      if (press !== e.press) begin
        $error("pressure_q24_8 expected %0h got %0h", e.press, press);
        errors++;
      end
      if (inv !== e.inv) begin
        $error("pressure_invalid expected %0b got %0b", e.inv, inv);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [19:0] in_raw_temperature;
  logic [19:0] in_raw_pressure;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_temperature_centi;
  logic [31:0] out_pressure_q24_8;
  logic        out_pressure_invalid;

  compensation_board board = new();
  bit calm;       // no idling on either side
  bit hold_req;   // receiver holds off for a long stretch
  int quiet_cycles;

  baro_temp_pressure_compensation i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_raw_temperature(in_raw_temperature), .in_raw_pressure(in_raw_pressure),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_temperature_centi(out_temperature_centi),
    .out_pressure_q24_8(out_pressure_q24_8),
    .out_pressure_invalid(out_pressure_invalid)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // monitor: both transfers sampled at the edge that accepts them
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_input(in_raw_temperature, in_raw_pressure);
      if (out_valid && !out_stall)
        board.check_result(out_temperature_centi, out_pressure_q24_8, out_pressure_invalid);
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, a calm stretch, and one long hold-off
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 27);
      end
    end
  end

  // all four registers back to back, enable raised once and lowered once
  task automatic write_calibration(logic [63:0] tc, logic [63:0] plo, logic [63:0] phi,
                                   logic [63:0] plast);
    logic [63:0] vals [4];
    vals = '{tc, plo, phi, plast};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en   <= 1'b1;
      cfg_index   <= cfg_reg_t'(i);
      cfg_wr_data <= vals[i];
      @(posedge clk);
      board.load(cfg_reg_t'(i), vals[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // one sample pair, held until its transfer
  task automatic send_sample(logic [19:0] raw_t, logic [19:0] raw_p);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_raw_temperature <= raw_t;
    in_raw_pressure    <= raw_p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_sample();
    if ($urandom_range(99) < 60)
      send_sample(20'($urandom_range(560000, 440000)), 20'($urandom_range(450000, 250000)));
    else
      send_sample(20'($urandom), 20'($urandom));
  endtask

  task automatic drain();
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  logic [19:0] edge_vals [6] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF,
                                 20'hAAAAA, 20'h55555};
  logic [63:0] typ_plo, typ_phi;

  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= REG_TEMP_CALIB;
    cfg_wr_data        <= '0;
    in_valid           <= 1'b0;
    in_raw_temperature <= '0;
    in_raw_pressure    <= '0;
    quiet_cycles       <= 0;
    calm = 0;
    hold_req = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // typical factory words, lanes listed from bit 63 downward
    typ_plo = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
    typ_phi = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        drain();
        case (ph)
          1: write_calibration({$urandom, $urandom} & 64'hFFFF_0000_0000_0000 |
                               {16'h0, -16'sd1000, 16'd26435, 16'd27504},
                               typ_plo, typ_phi, {$urandom, 16'd6000});
          2: write_calibration('1, '1, '1, '1);
          3: write_calibration(64'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                               64'h8000_8000_8000_8000, 64'h8000);
          4: write_calibration(64'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_7FFF,
                               64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
          // zero p1 forces a zero divisor with live temperature words
          5: write_calibration({$urandom, $urandom}, {$urandom, 16'h0000},
                               {$urandom, $urandom}, {$urandom, $urandom});
          default: write_calibration({$urandom, $urandom}, {$urandom, $urandom},
                                     {$urandom, $urandom}, {$urandom, $urandom});
        endcase
      end
      calm = (ph == 6);
      if (ph == 7) hold_req = 1;
      if (ph == 1) begin
        // field extremes and bit patterns on both raw readings
        foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[5 - i]);
        foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[i]);
        send_sample(20'd519888, 20'd415148);
        repeat (200) send_random_sample();
      end else begin
        repeat (140) send_random_sample();
      end
    end
    in_valid <= 1'b0;
    calm = 0;
    drain();

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
